FILE: design/pkct_pkg.sv
// Shared constants, word types and the controller state type of the per-key cooldown table.
package pkct_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 64;
    localparam int TIME_W  = 64;

    typedef struct packed {
        logic [KEY_W-1:0]  client_key;
        logic [TIME_W-1:0] request_time;
    } t_in_word;

    typedef struct packed {
        logic granted;
        logic table_full;
    } t_out_word;

    // request walking down the row of cells, collecting hit and first free slot
    typedef struct packed {
        logic              active;
        logic [KEY_W-1:0]  client_key;
        logic [TIME_W-1:0] request_time;
        logic              hit;
        logic              found;
        logic [IDX_W-1:0]  free_idx;
    } t_probe;

    // broadcast write of a granted key into one cell
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
    } t_commit;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

endpackage

FILE: design/per_key_cooldown_table.sv
// Top level of the per-key cooldown table: request controller, row of entry cells, result register.
//
// Each request word walks a row of ENTRIES cells, one cell per cycle; every cell expires
// its entry against the request time, compares the key and notes the first free slot.
// When the word leaves the last cell the grant is written into the chosen cell and the
// result goes to the output register. The controller accepts no new word until the result
// has moved from the result register to the output register. A result waiting on a
// stalled output overlaps the next walk; only a stall that lasts past the end of that walk
// holds the controller until the waiting word is taken. Words are taken one at a time.
// No clearing pass follows reset: valid bits clear at once.
module per_key_cooldown_table import pkct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word
);

    t_state            r_state;
    t_state            n_state;
    logic [TIME_W-1:0] r_cooldown;
    t_out_word         r_res;
    t_out_word         n_res;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_word         r_out_word;
    t_out_word         n_out_word;
    logic              w_accept;
    t_commit           w_commit;
    t_probe            w_head;
    t_probe            w_probe [0:ENTRIES];
    logic [ENTRIES-1:0] w_active;
    t_probe            w_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_head              = '0;
        w_head.active       = w_accept;
        w_head.client_key   = i_in_word.client_key;
        w_head.request_time = i_in_word.request_time;
    end

    assign w_probe[0] = w_head;

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            pkct_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_index    (IDX_W'(k)),
                .i_cooldown (r_cooldown),
                .i_probe    (w_probe[k]),
                .i_commit   (w_commit),
                .o_probe    (w_probe[k+1])
            );
            assign w_active[k] = w_probe[k+1].active;
        end
    endgenerate

    assign w_last = w_probe[ENTRIES];

    always_comb begin
        w_commit       = '0;
        w_commit.we    = (r_state == S_WALK) && w_last.active && !w_last.hit && w_last.found;
        w_commit.idx   = w_last.free_idx;
        w_commit.key   = w_last.client_key;
        w_commit.stamp = w_last.request_time;
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_last.active) begin
                    n_res.granted    = !w_last.hit;
                    n_res.table_full = !w_last.hit && !w_last.found;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cooldown  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cooldown <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // only one request is ever in the row
    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_active) <= 1)
        else $error("more than one probe in the cell row");

    // the row is empty whenever the controller is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_active == '0))
        else $error("probe in the row while idle");

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_WALK))
        else $error("accepted word did not start a walk");

    // a refusal never reports a full table
    a_refuse_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.granted || !o_out_word.table_full))
        else $error("refused word flagged table full");

endmodule

FILE: design/pkct_cell.sv
// One table entry: expires itself, checks the key and passes the probe to the next cell.
module pkct_cell import pkct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [TIME_W-1:0] i_cooldown,
    input  t_probe            i_probe,
    input  t_commit           i_commit,
    output t_probe            o_probe
);

    logic              r_valid;
    logic              n_valid;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_stamp;
    t_probe            r_probe;
    t_probe            n_probe;
    logic [TIME_W-1:0] w_age;
    logic              w_live;
    logic              w_write;

    // age wraps modulo 2^64
    assign w_age   = i_probe.request_time - r_stamp;
    assign w_live  = r_valid && (w_age < i_cooldown);
    assign w_write = i_commit.we && (i_commit.idx == i_index);

    always_comb begin
        n_valid = r_valid;
        n_probe = i_probe;
        if (w_write) begin
            n_valid = 1'b1;
        end else if (i_probe.active) begin
            n_valid = w_live;
        end
        if (i_probe.active) begin
            if (w_live && (r_key == i_probe.client_key)) begin
                n_probe.hit = 1'b1;
            end
            if (!i_probe.found && !w_live) begin
                n_probe.found    = 1'b1;
                n_probe.free_idx = i_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_probe.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_key   <= i_commit.key;
            r_stamp <= i_commit.stamp;
        end
    end

    assign o_probe = r_probe;

endmodule
